[rtl/core/ate_pkg.sv]
package ate_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [3:0] KIND_APPEND    = 4'd0;
  localparam logic [3:0] KIND_INS_START = 4'd1;
  localparam logic [3:0] KIND_INS_AFTER = 4'd2;
  localparam logic [3:0] KIND_REM_AT    = 4'd3;
  localparam logic [3:0] KIND_REM_VAL   = 4'd4;
  localparam logic [3:0] KIND_LSEARCH   = 4'd5;
  localparam logic [3:0] KIND_BSEARCH   = 4'd6;
  localparam logic [3:0] KIND_SORT      = 4'd7;
  localparam logic [3:0] KIND_READ      = 4'd8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [3:0]         kind;
    logic [5:0]         elem_index;
    logic signed [31:0] elem_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         result_index;
    logic signed [31:0] result_value;
    logic [6:0]         length;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR, S_LS_RD, S_LS_CMP,
    S_BS_RD, S_BS_CMP, S_RD_WAIT, S_SORT_MUL, S_SORT_PASS, S_SRT_RA, S_SRT_RB,
    S_SRT_CMP, S_SRT_WB, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_DECODE, OP_INS_STEP, OP_INS_MOVE, OP_DEL_STEP, OP_DEL_MOVE,
    OP_LS_STEP, OP_LS_CMP, OP_BS_STEP, OP_BS_CMP, OP_RD_TAKE, OP_GAP_MUL,
    OP_GAP_SET, OP_SRT_RA, OP_SRT_RB, OP_SRT_CMP, OP_SRT_WB
  } dp_op_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       full;
    logic       idx_bad;
    logic       at_pos;
    logic       del_end;
    logic       ls_end;
    logic       match;
    logic       bs_empty;
    logic       pass_end;
    logic       sort_done;
    logic       swap;
  } dp_stat_t;

endpackage

[rtl/core/ate_datapath.sv]
module ate_datapath import ate_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_op_t   op,
  input  req_t     req,
  output dp_stat_t stat,
  output rsp_t     rsp
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int XW   = CW + 4;
  localparam int PW   = 2 * XW;
  localparam logic [XW-1:0] RECIP = XW'((2 ** XW) / 13);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata, tmp, val, rvalue;
  logic [3:0]    kind;
  logic [5:0]    idx, rindex;
  logic [1:0]    status;
  logic [CW-1:0] count, ptr, pos, lo, hi, gap;
  logic [XW-1:0] qe;
  logic          done_flag;

  logic          re, we;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_data;
  logic [CW:0]   ptr_p1, ptr_gap;
  logic [CW-1:0] mid, newgap;
  logic [XW-1:0] x, qfix;
  logic [PW-1:0] prod;
  logic [XW+3:0] q13, rem;
  logic          full, idx_bad, match, gap_small;

  assign ptr_p1  = {1'b0, ptr} + 1'b1;
  assign ptr_gap = {1'b0, ptr} + {1'b0, gap};
  assign mid     = lo + ((hi - lo - 1'b1) >> 1);
  assign x       = (XW'(gap) << 3) + (XW'(gap) << 1);
  assign prod    = PW'(x) * PW'(RECIP);
  assign q13     = ((XW + 4)'(qe) << 3) + ((XW + 4)'(qe) << 2) + (XW + 4)'(qe);
  assign rem     = (XW + 4)'(x) - q13;
  assign qfix    = (rem >= (XW + 4)'(13)) ? qe + 1'b1 : qe;
  assign newgap  = CW'(qfix);
  assign gap_small = (qfix <= XW'(1));
  assign full    = (count >= CAP_C);
  assign idx_bad = (CMPW'(idx) >= CMPW'(count));
  assign match   = (rdata == val);

  assign stat.kind      = kind;
  assign stat.full      = full;
  assign stat.idx_bad   = idx_bad;
  assign stat.at_pos    = (ptr == pos);
  assign stat.del_end   = (ptr_p1 >= {1'b0, count});
  assign stat.ls_end    = (ptr >= count);
  assign stat.match     = match;
  assign stat.bs_empty  = (lo >= hi);
  assign stat.pass_end  = (ptr_gap >= {1'b0, count});
  assign stat.sort_done = done_flag;
  assign stat.swap      = ($signed(tmp) > $signed(rdata));

  assign rsp.status       = status;
  assign rsp.result_index = rindex;
  assign rsp.result_value = rvalue;
  assign rsp.length       = 7'(count);

  always_comb begin
    re      = 1'b0;
    we      = 1'b0;
    rd_addr = IW'(ptr);
    wr_addr = IW'(ptr);
    wr_data = rdata;
    unique case (op)
      OP_DECODE: begin
        if (kind == KIND_READ && !idx_bad) begin
          re      = 1'b1;
          rd_addr = IW'(idx);
        end
      end
      OP_INS_STEP: begin
        if (ptr == pos) begin
          we      = 1'b1;
          wr_addr = IW'(pos);
          wr_data = val;
        end else begin
          re      = 1'b1;
          rd_addr = IW'(ptr - 1'b1);
        end
      end
      OP_INS_MOVE, OP_DEL_MOVE: we = 1'b1;
      OP_DEL_STEP: begin
        if (!stat.del_end) begin
          re      = 1'b1;
          rd_addr = IW'(ptr_p1);
        end
      end
      OP_LS_STEP: re = !stat.ls_end;
      OP_BS_STEP: begin
        re      = !stat.bs_empty;
        rd_addr = IW'(mid);
      end
      OP_SRT_RA: re = !stat.pass_end;
      OP_SRT_RB: begin
        re      = 1'b1;
        rd_addr = IW'(ptr_gap);
      end
      OP_SRT_CMP: we = stat.swap;
      OP_SRT_WB: begin
        we      = 1'b1;
        wr_addr = IW'(ptr_gap);
        wr_data = tmp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (re) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        kind   <= req.kind;
        idx    <= req.elem_index;
        val    <= req.elem_value;
        status <= ST_OK;
        rindex <= '0;
        rvalue <= '0;
      end
      OP_DECODE: begin
        ptr <= count;
        pos <= count;
        lo  <= '0;
        hi  <= count;
        unique case (kind)
          KIND_APPEND, KIND_INS_START: begin
            if (full) status <= ST_FULL;
            if (kind == KIND_INS_START) pos <= '0;
          end
          KIND_INS_AFTER: begin
            if (idx_bad) status <= ST_BAD_INDEX;
            else if (full) status <= ST_FULL;
            pos <= CW'(idx) + 1'b1;
          end
          KIND_REM_AT: begin
            if (idx_bad) status <= ST_BAD_INDEX;
            ptr <= CW'(idx);
          end
          KIND_REM_VAL, KIND_LSEARCH: ptr <= '0;
          KIND_READ: if (idx_bad) status <= ST_BAD_INDEX;
          default: ;
        endcase
      end
      OP_INS_MOVE: ptr <= ptr - 1'b1;
      OP_DEL_MOVE: ptr <= CW'(ptr_p1);
      OP_LS_STEP: if (stat.ls_end) status <= ST_NOT_FOUND;
      OP_LS_CMP: begin
        if (match) begin
          if (kind != KIND_REM_VAL) rindex <= 6'(ptr);
        end else begin
          ptr <= CW'(ptr_p1);
        end
      end
      OP_BS_STEP: begin
        if (stat.bs_empty) status <= ST_NOT_FOUND;
        else ptr <= mid;
      end
      OP_BS_CMP: begin
        if (match) rindex <= 6'(ptr);
        else if ($signed(val) > $signed(rdata)) lo <= CW'(ptr_p1);
        else hi <= ptr;
      end
      OP_RD_TAKE: rvalue <= rdata;
      OP_GAP_MUL: qe <= prod[PW-1:XW];
      OP_SRT_RB: tmp <= rdata;
      OP_SRT_CMP: if (!stat.swap) ptr <= CW'(ptr_p1);
      OP_SRT_WB: ptr <= CW'(ptr_p1);
      OP_GAP_SET: ptr <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      gap       <= '0;
      done_flag <= 1'b0;
    end else begin
      unique case (op)
        OP_DECODE: if (kind == KIND_SORT) gap <= count;
        OP_INS_STEP: if (ptr == pos) count <= count + 1'b1;
        OP_DEL_STEP: if (stat.del_end) count <= count - 1'b1;
        OP_GAP_SET: begin
          gap       <= gap_small ? CW'(1) : newgap;
          done_flag <= gap_small;
        end
        OP_SRT_CMP: if (stat.swap) done_flag <= 1'b0;
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C) else $error("element count beyond capacity");

  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    op == OP_GAP_SET |=> gap != '0) else $error("sort gap became zero");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    op == OP_INS_STEP && ptr == pos |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the table");

endmodule

[rtl/core/ate_ctrl.sv]
module ate_ctrl import ate_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_op_t   op,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_DECODE;
      S_DECODE: begin
        unique case (stat.kind)
          KIND_APPEND, KIND_INS_START: state_next = stat.full ? S_FIN : S_INS_RD;
          KIND_INS_AFTER:
            state_next = (stat.idx_bad || stat.full) ? S_FIN : S_INS_RD;
          KIND_REM_AT: state_next = stat.idx_bad ? S_FIN : S_DEL_RD;
          KIND_REM_VAL, KIND_LSEARCH: state_next = S_LS_RD;
          KIND_BSEARCH: state_next = S_BS_RD;
          KIND_SORT: state_next = S_SORT_MUL;
          KIND_READ: state_next = stat.idx_bad ? S_FIN : S_RD_WAIT;
          default: state_next = S_FIN;
        endcase
      end
      S_INS_RD: state_next = stat.at_pos ? S_FIN : S_INS_WR;
      S_INS_WR: state_next = S_INS_RD;
      S_DEL_RD: state_next = stat.del_end ? S_FIN : S_DEL_WR;
      S_DEL_WR: state_next = S_DEL_RD;
      S_LS_RD: state_next = stat.ls_end ? S_FIN : S_LS_CMP;
      S_LS_CMP: begin
        if (!stat.match) state_next = S_LS_RD;
        else if (stat.kind == KIND_REM_VAL) state_next = S_DEL_RD;
        else state_next = S_FIN;
      end
      S_BS_RD: state_next = stat.bs_empty ? S_FIN : S_BS_CMP;
      S_BS_CMP: state_next = stat.match ? S_FIN : S_BS_RD;
      S_RD_WAIT: state_next = S_FIN;
      S_SORT_MUL: state_next = S_SORT_PASS;
      S_SORT_PASS: state_next = S_SRT_RA;
      S_SRT_RA: begin
        if (!stat.pass_end) state_next = S_SRT_RB;
        else state_next = stat.sort_done ? S_FIN : S_SORT_MUL;
      end
      S_SRT_RB: state_next = S_SRT_CMP;
      S_SRT_CMP: state_next = stat.swap ? S_SRT_WB : S_SRT_RA;
      S_SRT_WB: state_next = S_SRT_RA;
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_FIN);
    unique case (state)
      S_IDLE:      op = start ? OP_LOAD : OP_NOP;
      S_DECODE:    op = OP_DECODE;
      S_INS_RD:    op = OP_INS_STEP;
      S_INS_WR:    op = OP_INS_MOVE;
      S_DEL_RD:    op = OP_DEL_STEP;
      S_DEL_WR:    op = OP_DEL_MOVE;
      S_LS_RD:     op = OP_LS_STEP;
      S_LS_CMP:    op = OP_LS_CMP;
      S_BS_RD:     op = OP_BS_STEP;
      S_BS_CMP:    op = OP_BS_CMP;
      S_RD_WAIT:   op = OP_RD_TAKE;
      S_SORT_MUL:  op = OP_GAP_MUL;
      S_SORT_PASS: op = OP_GAP_SET;
      S_SRT_RA:    op = OP_SRT_RA;
      S_SRT_RB:    op = OP_SRT_RB;
      S_SRT_CMP:   op = OP_SRT_CMP;
      S_SRT_WB:    op = OP_SRT_WB;
      default:     op = OP_NOP;
    endcase
  end

endmodule

[rtl/core/array_table_engine_top.sv]
// Each request runs from decode to done through a sequence of states: a rejected
// or unused request goes straight to done, a read adds a wait state and a plain
// append its write state; shifts and linear searches step per element moved or
// scanned, a binary search per probe, a comb sort per compare plus a gap update
// per pass. Requests are taken one at a time, the next in the cycle after done;
// the receiver cannot stall. Synchronous reset empties the table; no memory clearing pass is needed.
module array_table_engine_top import ate_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  dp_op_t   op;
  dp_stat_t stat;

  ate_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  ate_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .req  (req),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

[bench/array_table_engine_top_tb.sv]
module array_table_engine_top_tb;
  import ate_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 2 * CAP + 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t rsp;

  array_table_engine_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
  );

  always #10 clk = ~clk;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic signed [31:0] table_words[CAP];
  int table_len = 0;
  int idle_pct = 0;
  int mismatches = 0;
  int transfers = 0;
  int results_seen = 0;
  int cycles = 0;
  int kind_hits[16];
  int full_hits = 0;

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int pos;
    int lo;
    int hi;
    int mid;
    int gap;
    bit fin;
    bit full;
    logic signed [31:0] t;
    o = '0;
    pos = -1;
    full = (table_len >= CAP);
    case (r.kind)
      KIND_APPEND, KIND_INS_START: begin
        if (full) o.status = ST_FULL;
        else begin
          pos = (r.kind == KIND_APPEND) ? table_len : 0;
          for (int i = table_len; i > pos; i--) table_words[i] = table_words[i-1];
          table_words[pos] = r.elem_value;
          table_len++;
        end
      end
      KIND_INS_AFTER: begin
        if (r.elem_index >= table_len) o.status = ST_BAD_INDEX;
        else if (full) o.status = ST_FULL;
        else begin
          pos = r.elem_index + 1;
          for (int i = table_len; i > pos; i--) table_words[i] = table_words[i-1];
          table_words[pos] = r.elem_value;
          table_len++;
        end
      end
      KIND_REM_AT, KIND_REM_VAL: begin
        if (r.kind == KIND_REM_AT) begin
          if (r.elem_index >= table_len) o.status = ST_BAD_INDEX;
          else pos = r.elem_index;
        end else begin
          for (int i = 0; i < table_len; i++)
            if (pos < 0 && table_words[i] == r.elem_value) pos = i;
          if (pos < 0) o.status = ST_NOT_FOUND;
        end
        if (pos >= 0) begin
          for (int i = pos; i + 1 < table_len; i++) table_words[i] = table_words[i+1];
          table_len--;
        end
      end
      KIND_LSEARCH: begin
        for (int i = 0; i < table_len; i++)
          if (pos < 0 && table_words[i] == r.elem_value) pos = i;
        if (pos < 0) o.status = ST_NOT_FOUND;
        else o.result_index = pos[5:0];
      end
      KIND_BSEARCH: begin
        lo = 0;
        hi = table_len;
        while (lo < hi && pos < 0) begin
          mid = lo + (hi - 1 - lo) / 2;
          if (table_words[mid] == r.elem_value) pos = mid;
          else if (r.elem_value > table_words[mid]) lo = mid + 1;
          else hi = mid;
        end
        if (pos < 0) o.status = ST_NOT_FOUND;
        else o.result_index = pos[5:0];
      end
      KIND_SORT: begin
        gap = table_len;
        fin = 1'b0;
        while (!fin) begin
          gap = (gap * 10) / 13;
          if (gap <= 1) begin
            gap = 1;
            fin = 1'b1;
          end
          for (int i = 0; i + gap < table_len; i++) begin
            if (table_words[i] > table_words[i+gap]) begin
              t = table_words[i];
              table_words[i] = table_words[i+gap];
              table_words[i+gap] = t;
              fin = 1'b0;
            end
          end
        end
      end
      KIND_READ: begin
        if (r.elem_index >= table_len) o.status = ST_BAD_INDEX;
        else o.result_value = table_words[r.elem_index];
      end
      default: ;
    endcase
    o.length = table_len[6:0];
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (table_len >= CAP) full_hits++;
        kind_hits[req.kind]++;
        expected_rsps.push_back(apply_request(req));
        transfers++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          req <= pending_reqs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", rsp);
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status || rsp.result_index !== e.result_index ||
            rsp.result_value !== e.result_value || rsp.length !== e.length) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d idx=%0d val=%0d len=%0d, got st=%0d idx=%0d val=%0d len=%0d",
                     e.status, e.result_index, e.result_value, e.length,
                     rsp.status, rsp.result_index, rsp.result_value, rsp.length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_req(logic [3:0] k, logic [5:0] idx, logic signed [31:0] v);
    req_t r;
    r.kind = k;
    r.elem_index = idx;
    r.elem_value = v;
    pending_reqs.push_back(r);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4, 5: return $signed($urandom_range(0, 11)) - 6;
      default: return $signed($urandom);
    endcase
  endfunction

  // mode 0 mixed, 1 grow, 2 shrink
  task automatic gen_random(int n, int mode);
    int r;
    logic [3:0] k;
    logic [5:0] idx;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (mode == 1) r = (r < 70) ? r / 24 : r;
      else if (mode == 2) r = (r < 50) ? 40 + r / 5 : r;
      if (r < 14) k = KIND_APPEND;
      else if (r < 24) k = KIND_INS_START;
      else if (r < 36) k = KIND_INS_AFTER;
      else if (r < 46) k = KIND_REM_AT;
      else if (r < 56) k = KIND_REM_VAL;
      else if (r < 68) k = KIND_LSEARCH;
      else if (r < 80) k = KIND_BSEARCH;
      else if (r < 83) k = KIND_SORT;
      else if (r < 97) k = KIND_READ;
      else k = 4'($urandom_range(9, 15));
      idx = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 15)) : 6'($urandom);
      push_req(k, idx, pick_value());
    end
  endtask

  task automatic drain_all();
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (start || expected_rsps.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_req(KIND_READ, 6'd0, 32'sd0);
    push_req(KIND_REM_AT, 6'd0, 32'sd0);
    push_req(KIND_REM_VAL, 6'd0, 32'sd1);
    push_req(KIND_LSEARCH, 6'd0, 32'sd1);
    push_req(KIND_BSEARCH, 6'd0, 32'sd1);
    push_req(KIND_SORT, 6'd0, 32'sd0);
    push_req(4'd15, 6'd63, 32'shffffffff);
    push_req(KIND_APPEND, 6'd0, 32'sh7fffffff);
    push_req(KIND_APPEND, 6'd0, 32'sh80000000);
    push_req(KIND_INS_START, 6'd0, -32'sd1);
    push_req(KIND_INS_AFTER, 6'd0, 32'sd5);
    push_req(KIND_INS_AFTER, 6'd63, 32'sd7);
    push_req(KIND_READ, 6'd63, 32'sd0);
    push_req(KIND_READ, 6'd0, 32'sd0);
    push_req(KIND_LSEARCH, 6'd0, -32'sd1);
    push_req(KIND_BSEARCH, 6'd0, 32'sh7fffffff);
    push_req(KIND_SORT, 6'd0, 32'sd0);
    push_req(KIND_BSEARCH, 6'd0, 32'sd5);
    push_req(KIND_BSEARCH, 6'd0, 32'sd4);
    push_req(KIND_REM_VAL, 6'd0, 32'sd9);
    push_req(KIND_REM_VAL, 6'd0, 32'sd5);
    push_req(KIND_REM_AT, 6'd2, 32'sd0);
    push_req(KIND_READ, 6'd1, 32'sd0);
    push_req(4'd9, 6'd0, 32'sd0);
    drain_all();

    // hold off until the table settles, then run each idling phase
    idle_pct = 0;
    gen_random(90, 1);
    gen_random(20, 0);
    drain_all();
    idle_pct = 66;
    gen_random(60, 0);
    gen_random(40, 2);
    drain_all();
    idle_pct = 7;
    gen_random(90, 1);
    gen_random(30, 0);
    drain_all();
    idle_pct = 0;
    gen_random(50, 2);
    gen_random(20, 0);
    drain_all();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_rsps.size());
    end
    $display("%0d requests sent, %0d results checked, %0d sorts, %0d requests on a full table",
             transfers, results_seen, kind_hits[KIND_SORT], full_hits);
    $display("%0d mismatches over %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[array_table_engine_top.f]
rtl/core/ate_pkg.sv
rtl/core/ate_datapath.sv
rtl/core/ate_ctrl.sv
rtl/core/array_table_engine_top.sv
bench/array_table_engine_top_tb.sv
